// ----- src/rau_pkg.sv -----
// Shared types, constants and command codes of the rational arithmetic unit.
package rau_pkg;

  localparam int W = 32;

  typedef logic [W-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIVZ  = 2'd1,
    ST_OVFL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  localparam word_t WSIGN = {1'b1, {(W-1){1'b0}}};

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_LOAD   = 4'd1,  // take operands from the input beat
    OP_PREP   = 4'd2,  // zero fix and sign move of (x,y); flags overflow
    OP_GSTART = 4'd3,  // load GCD registers from |x| and y (sub 1: from ad and bd)
    OP_GSTEP  = 4'd4,  // start a remainder for the GCD
    OP_DSTART = 4'd5,  // divider: x / g  (signed)
    OP_DSTART2= 4'd6,  // divider: y / g
    OP_STX    = 4'd7,  // store quotient into x; sub 1: GCD step, ga <= gb and gb <= rem
    OP_STY    = 4'd8,  // store quotient into y
    OP_SAVE_A = 4'd9,  // save normalized (x,y) as operand a; load b into (x,y)
    OP_SAVE_B = 4'd10, // save normalized (x,y) as operand b
    OP_COMB   = 4'd11, // combine step selected by sub-step
    OP_FINISH = 4'd12  // write result register
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] sub;
  } cmd_bus_t;

  typedef struct packed {
    logic ovf;      // denominator equals most negative value and numerator is nonzero
    logic gcd_done; // GCD divisor register is zero
    logic div_busy;
    logic bn_zero;
  } stat_bus_t;

  function automatic word_t wneg(input word_t x);
    return word_t'(-x);
  endfunction

  function automatic word_t wmag(input word_t x);
    return x[W-1] ? wneg(x) : x;
  endfunction

endpackage

// ----- src/rau_if.sv -----
// Valid/ready channel interface carrying one payload beat.
interface rau_if #(type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/rational_arith_unit_top.sv -----
// Top level of the rational arithmetic unit.
//
// The input channel carries one beat with cmd and two fractions a_num/a_den
// and b_num/b_den. The output channel returns one beat per input beat with
// the reduced numerator, the positive denominator and a status code
// (ok, divide by zero, denominator overflow).
//
// Items are processed one at a time. A single restoring divider that yields
// one quotient bit per cycle does every GCD remainder and every exact
// division; each divider use is a start, one bit step per quotient bit and
// a store. The time an item takes is set by the number of Euclid steps in
// each normalization. The multiplier forms one 32 by 32 product per cycle.
// The next input beat is taken the cycle after the result beat leaves.
//
// After the result beat is shown, it holds until the receiver takes it;
// the input stays not ready during that time. Synchronous reset returns the
// controller to idle with no beat pending.
module rational_arith_unit_top (
  input logic clk,
  input logic rst,
  rau_if.sink   in_ch,
  rau_if.source out_ch
);
  rau_pkg::cmd_bus_t  ctl;
  rau_pkg::stat_bus_t stat;
  rau_pkg::status_t   fin_status;
  rau_pkg::status_t   res_status;
  rau_pkg::word_t     res_den_w;

  rau_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .in_cmd(in_ch.data.cmd), .stat(stat), .ctl(ctl), .fin_status(fin_status)
  );

  rau_datapath u_dp (
    .clk(clk), .rst(rst), .ctl(ctl),
    .in_cmd(in_ch.data.cmd),
    .in_a_num(in_ch.data.a_num), .in_a_den(in_ch.data.a_den),
    .in_b_num(in_ch.data.b_num), .in_b_den(in_ch.data.b_den),
    .fin_status(fin_status), .stat(stat),
    .res_num(out_ch.data.res_num), .res_den(res_den_w), .res_status(res_status)
  );

  assign out_ch.data.res_den = res_den_w[30:0];
  assign out_ch.data.status  = res_status;
endmodule

// ----- src/rau_div.sv -----
// Restoring divider, one quotient bit per cycle, for unsigned magnitudes.
module rau_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  rau_pkg::word_t dividend,
  input  rau_pkg::word_t divisor,
  output logic           busy,
  output rau_pkg::word_t quo,
  output rau_pkg::word_t rem
);
  localparam int CW = $clog2(rau_pkg::W + 1);

  logic [CW-1:0]  cnt;
  rau_pkg::word_t d;
  logic [rau_pkg::W:0] trial;

  assign trial = {rem, quo[rau_pkg::W-1]} - {1'b0, d};

  // Shift one dividend bit into the partial remainder each cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(rau_pkg::W);
      quo  <= dividend;
      rem  <= '0;
      d    <= divisor;
    end else if (busy) begin
      if (!trial[rau_pkg::W]) begin
        rem <= trial[rau_pkg::W-1:0];
        quo <= {quo[rau_pkg::W-2:0], 1'b1};
      end else begin
        rem <= {rem[rau_pkg::W-2:0], quo[rau_pkg::W-1]};
        quo <= {quo[rau_pkg::W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

// ----- src/rau_datapath.sv -----
// Datapath: operand registers, GCD registers, shared divider and multiplier.
module rau_datapath (
  input  logic                clk,
  input  logic                rst,
  input  rau_pkg::cmd_bus_t   ctl,
  input  logic [1:0]          in_cmd,
  input  rau_pkg::word_t      in_a_num,
  input  rau_pkg::word_t      in_a_den,
  input  rau_pkg::word_t      in_b_num,
  input  rau_pkg::word_t      in_b_den,
  input  rau_pkg::status_t    fin_status,
  output rau_pkg::stat_bus_t  stat,
  output rau_pkg::word_t      res_num,
  output rau_pkg::word_t      res_den,
  output rau_pkg::status_t    res_status
);
  rau_pkg::word_t x, y, an, ad, bn, bd, ga, gb, l, p, ls;
  logic [1:0] cmd;
  logic       dstart, dbusy, dneg;
  rau_pkg::word_t dnd, dvs, quo, rem, qs;

  rau_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .dividend(dnd), .divisor(dvs),
    .busy(dbusy), .quo(quo), .rem(rem)
  );

  // A zero numerator turns the fraction into 0/1 before the sign move, so
  // the most negative denominator only overflows with a nonzero numerator.
  assign stat.ovf      = (y == rau_pkg::WSIGN) && (x != '0);
  assign stat.gcd_done = (gb == '0);
  assign stat.div_busy = dbusy;
  // The normalized numerator of the second operand sits in x while saving.
  assign stat.bn_zero  = (x == '0);

  assign qs = dneg ? rau_pkg::wneg(quo) : quo;

  // Divider operand selection.
  always_comb begin
    dstart = 1'b0;
    dnd    = '0;
    dvs    = '0;
    case (ctl.op)
      rau_pkg::OP_GSTEP: begin
        dstart = 1'b1; dnd = ga; dvs = gb;
      end
      rau_pkg::OP_DSTART: begin
        dstart = 1'b1; dnd = rau_pkg::wmag(x); dvs = (ga == '0) ? 1 : ga;
      end
      rau_pkg::OP_DSTART2: begin
        dstart = 1'b1; dnd = y; dvs = (ga == '0) ? 1 : ga;
      end
      rau_pkg::OP_COMB: begin
        // sub 1: l = (ad*bd)/g ; sub 3: l/ad ; sub 5: l/bd
        case (ctl.sub)
          4'd1: begin dstart = 1'b1; dnd = rau_pkg::wmag(p); dvs = (ga == '0) ? 1 : ga; end
          4'd3: begin dstart = 1'b1; dnd = rau_pkg::wmag(l); dvs = ad; end
          4'd5: begin dstart = 1'b1; dnd = rau_pkg::wmag(l); dvs = bd; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Register updates per command.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_status <= rau_pkg::ST_OK;
      dneg       <= 1'b0;
    end else begin
      case (ctl.op)
        rau_pkg::OP_LOAD: begin
          cmd <= in_cmd;
          x <= in_a_num; y <= in_a_den;
          bn <= in_b_num; bd <= in_b_den;
        end
        rau_pkg::OP_PREP: begin
          if (x == '0 || y == '0) begin
            x <= '0; y <= 1;
          end else if (y[rau_pkg::W-1] && y != rau_pkg::WSIGN) begin
            x <= rau_pkg::wneg(x); y <= rau_pkg::wneg(y);
          end
        end
        rau_pkg::OP_GSTART: begin
          if (ctl.sub == 4'd1) begin
            ga <= ad; gb <= bd;
          end else begin
            ga <= rau_pkg::wmag(x); gb <= y;
          end
        end
        rau_pkg::OP_GSTEP: ;
        rau_pkg::OP_DSTART: dneg <= x[rau_pkg::W-1] ^ ((ga == '0) ? 1'b0 : ga[rau_pkg::W-1]);
        rau_pkg::OP_DSTART2: dneg <= 1'b0;
        rau_pkg::OP_STX: begin
          if (ctl.sub == 4'd1) begin
            ga <= gb; gb <= rem;   // GCD step completes
          end else begin
            x <= qs;
          end
        end
        rau_pkg::OP_STY: y <= quo;
        rau_pkg::OP_SAVE_A: begin
          an <= x; ad <= y; x <= bn; y <= bd;
        end
        rau_pkg::OP_SAVE_B: begin
          bn <= x; bd <= y;
        end
        rau_pkg::OP_COMB: begin
          case (ctl.sub)
            4'd0: begin p <= rau_pkg::word_t'(ad * bd); end
            4'd1: dneg <= p[rau_pkg::W-1] ^ ((ga == '0) ? 1'b0 : ga[rau_pkg::W-1]);
            4'd2: l <= qs;
            4'd3: dneg <= l[rau_pkg::W-1] ^ ad[rau_pkg::W-1];
            4'd4: begin ls <= rau_pkg::word_t'(an * qs); end
            4'd5: dneg <= l[rau_pkg::W-1] ^ bd[rau_pkg::W-1];
            4'd6: begin
              p <= rau_pkg::word_t'(
                (cmd == rau_pkg::CMD_SUB ? rau_pkg::wneg(bn) : bn) * qs);
            end
            4'd7: begin x <= rau_pkg::word_t'(ls + p); y <= l; end
            4'd8: begin x <= rau_pkg::word_t'(an * bn); end
            4'd9: begin y <= rau_pkg::word_t'(ad * bd); end
            4'd10: begin x <= bd; y <= bn; end  // reciprocal of b
            default: ;
          endcase
        end
        rau_pkg::OP_FINISH: begin
          res_status <= fin_status;
          if (fin_status == rau_pkg::ST_OK) begin
            res_num <= x; res_den <= y;
          end else begin
            res_num <= '0; res_den <= 1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- src/rau_ctrl.sv -----
// Controller: sequences normalization, GCD and combine steps for one item.
module rau_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         in_cmd,
  input  rau_pkg::stat_bus_t stat,
  output rau_pkg::cmd_bus_t  ctl,
  output rau_pkg::status_t   fin_status
);
  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_PREP  = 14'b00000000000010,
    S_GST   = 14'b00000000000100,
    S_GCHK  = 14'b00000000001000,
    S_GWAIT = 14'b00000000010000,
    S_DX    = 14'b00000000100000,
    S_DXW   = 14'b00000001000000,
    S_DY    = 14'b00000010000000,
    S_DYW   = 14'b00000100000000,
    S_SAVE  = 14'b00001000000000,
    S_COMB  = 14'b00010000000000,
    S_CWAIT = 14'b00100000000000,
    S_FIN   = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  // Normalization passes: 0 a, 1 b, 2 reciprocal, 3 result.
  typedef enum logic [1:0] {
    P_A = 2'd0, P_B = 2'd1, P_R = 2'd2, P_RES = 2'd3
  } pass_t;

  state_t           state, state_next;
  pass_t            pass, pass_next;
  logic [3:0]       sub, sub_next;
  logic [1:0]       cmd, cmd_next;
  logic             lcm_g, lcm_g_next;
  rau_pkg::status_t st, st_next;

  assign in_ready   = (state == S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign fin_status = st;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass  <= P_A;
      sub   <= '0;
      cmd   <= '0;
      lcm_g <= 1'b0;
      st    <= rau_pkg::ST_OK;
    end else begin
      state <= state_next;
      pass  <= pass_next;
      sub   <= sub_next;
      cmd   <= cmd_next;
      lcm_g <= lcm_g_next;
      st    <= st_next;
    end
  end

  // Next-state and command decode.
  always_comb begin
    state_next = state;
    pass_next  = pass;
    sub_next   = sub;
    cmd_next   = cmd;
    lcm_g_next = lcm_g;
    st_next    = st;
    ctl.op     = rau_pkg::OP_NONE;
    ctl.sub    = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op     = rau_pkg::OP_LOAD;
          cmd_next   = in_cmd;
          pass_next  = P_A;
          st_next    = rau_pkg::ST_OK;
          lcm_g_next = 1'b0;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        ctl.op = rau_pkg::OP_PREP;
        if (stat.ovf) begin
          st_next    = rau_pkg::ST_OVFL;
          state_next = S_FIN;
        end else begin
          state_next = S_GST;
        end
      end
      S_GST: begin
        ctl.op     = rau_pkg::OP_GSTART;
        ctl.sub    = {3'd0, lcm_g};
        state_next = S_GCHK;
      end
      S_GCHK: begin
        if (stat.gcd_done) begin
          if (lcm_g) begin
            lcm_g_next = 1'b0;
            sub_next   = 4'd1;
            state_next = S_COMB;
          end else begin
            state_next = S_DX;
          end
        end else begin
          ctl.op     = rau_pkg::OP_GSTEP;
          state_next = S_GWAIT;
        end
      end
      S_GWAIT: begin
        if (!stat.div_busy) begin
          ctl.op     = rau_pkg::OP_STX;
          ctl.sub    = 4'd1;
          state_next = S_GCHK;
        end
      end
      S_DX: begin
        ctl.op     = rau_pkg::OP_DSTART;
        state_next = S_DXW;
      end
      S_DXW: begin
        if (!stat.div_busy) begin
          ctl.op     = rau_pkg::OP_STX;
          state_next = S_DY;
        end
      end
      S_DY: begin
        ctl.op     = rau_pkg::OP_DSTART2;
        state_next = S_DYW;
      end
      S_DYW: begin
        if (!stat.div_busy) begin
          ctl.op     = rau_pkg::OP_STY;
          state_next = S_SAVE;
        end
      end
      S_SAVE: begin
        case (pass)
          P_A: begin
            ctl.op     = rau_pkg::OP_SAVE_A;
            pass_next  = P_B;
            state_next = S_PREP;
          end
          P_B, P_R: begin
            ctl.op = rau_pkg::OP_SAVE_B;
            if (cmd == rau_pkg::CMD_ADD || cmd == rau_pkg::CMD_SUB) begin
              lcm_g_next = 1'b1;
              state_next = S_GST;
            end else if (cmd == rau_pkg::CMD_DIV && pass == P_B) begin
              if (stat.bn_zero) begin
                st_next    = rau_pkg::ST_DIVZ;
                state_next = S_FIN;
              end else begin
                sub_next   = 4'd10;
                state_next = S_COMB;
              end
            end else begin
              sub_next   = 4'd8;
              state_next = S_COMB;
            end
          end
          default: state_next = S_FIN;
        endcase
      end
      S_COMB: begin
        ctl.op  = rau_pkg::OP_COMB;
        ctl.sub = sub;
        case (sub)
          4'd0: begin sub_next = 4'd1; end
          4'd1, 4'd3, 4'd5: begin state_next = S_CWAIT; end
          4'd7, 4'd9: begin
            pass_next  = P_RES;
            state_next = S_PREP;
          end
          4'd10: begin
            pass_next  = P_R;
            state_next = S_PREP;
          end
          default: sub_next = sub + 4'd1;
        endcase
        // The LCM path first forms ad*bd before dividing by the GCD.
        if (sub == 4'd1 && state == S_COMB && !lcm_g && pass != P_RES) begin
          state_next = S_CWAIT;
        end
      end
      S_CWAIT: begin
        if (!stat.div_busy) begin
          sub_next   = sub + 4'd1;
          state_next = S_COMB;
        end
      end
      S_FIN: begin
        ctl.op     = rau_pkg::OP_FINISH;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // The GCD for the LCM finished: compute ad*bd, then divide.
    if (state == S_GCHK && stat.gcd_done && lcm_g) begin
      sub_next = 4'd0;
    end
  end
endmodule
